>>> hdl/gnms_pkg.sv
// shared constants, types and helpers for the gradient non-maximum suppression block
package gnms_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COMP_BITS   = 16;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WID_BITS    = COL_BITS + 1;
   localparam int HEIGHT_BITS = 16;
   localparam int VEC_BITS    = 2 * COMP_BITS;
   localparam int SQ_BITS     = 2 * COMP_BITS;
   localparam int NORM_BITS   = SQ_BITS + 1;
   localparam int LINE_BITS   = 2 * VEC_BITS;

   localparam int CSR_WIDTH_BITS  = 11;
   localparam int CSR_HEIGHT_BITS = 16;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [CSR_WIDTH_BITS-1:0]  RESET_FRAME_WIDTH  = 11'd640;
   localparam logic [CSR_HEIGHT_BITS-1:0] RESET_FRAME_HEIGHT = 16'd480;

   typedef struct packed {
      logic                   valid;
      logic                   emit;
      logic                   last;
      logic [COL_BITS-1:0]    pos_x;
      logic [HEIGHT_BITS-1:0] pos_y;
      logic [VEC_BITS-1:0]    top;
      logic [VEC_BITS-1:0]    mid;
      logic [VEC_BITS-1:0]    pix;
   } column_type;

   typedef struct packed {
      logic                   valid;
      logic [COL_BITS-1:0]    pos_x;
      logic [HEIGHT_BITS-1:0] pos_y;
      logic [COMP_BITS-1:0]   kept_x;
      logic [COMP_BITS-1:0]   kept_y;
      logic                   is_kept;
      logic                   last;
   } result_type;

   typedef struct packed {
      logic nz;
      logic neg;
   } offset_type;

   typedef struct packed {
      offset_type dx;
      offset_type dy;
   } dir_type;

   // offset along one axis: sign of c when 7*c*c >= o*o
   function automatic offset_type axis_offset(
      input logic                 c_zero,
      input logic                 c_neg,
      input logic [SQ_BITS-1:0]   sq_c,
      input logic [SQ_BITS-1:0]   sq_o
   );
      offset_type             off;
      logic [SQ_BITS+2:0]     seven_c;
      seven_c = ({3'b000, sq_c} << 3) - {3'b000, sq_c};
      off.nz  = !c_zero && !(seven_c < {3'b000, sq_o});
      off.neg = c_neg;
      return off;
   endfunction

endpackage

>>> hdl/gnms_ram.sv
// generic single-write, single-read ram with registered read data
module gnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/gnms_line_store.sv
// position counters, two-row line store and column assembly
module gnms_line_store import gnms_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   move,
   input  logic                   in_take,
   input  logic                   frame_start,
   input  logic [COMP_BITS-1:0]   vec_x,
   input  logic [COMP_BITS-1:0]   vec_y,
   input  logic [WID_BITS-1:0]    width_eff,
   input  logic [HEIGHT_BITS-1:0] height_eff,
   output column_type             col
);

   logic [COL_BITS-1:0]    col_count_ff, col_count_in;
   logic [HEIGHT_BITS-1:0] row_count_ff, row_count_in;
   logic [COL_BITS-1:0]    cx;
   logic [HEIGHT_BITS-1:0] cy;
   logic [WID_BITS-1:0]    cx_next;
   logic [HEIGHT_BITS:0]   cy_next;
   logic                   emit_in, last_in;
   logic [VEC_BITS-1:0]    pix_in;

   logic                   s1_valid_ff;
   logic                   s1_emit_ff, s1_last_ff;
   logic [COL_BITS-1:0]    s1_addr_ff;
   logic [HEIGHT_BITS-1:0] s1_row_ff;
   logic [VEC_BITS-1:0]    s1_pix_ff;
   logic                   s1_fwd_ff, s1_fwd_in;
   logic [LINE_BITS-1:0]   s1_fwd_data_ff;
   logic [LINE_BITS-1:0]   rd_data, line_word, wr_data;
   logic                   wr_en;

   always_comb begin
      cx      = frame_start ? '0 : col_count_ff;
      cy      = frame_start ? '0 : row_count_ff;
      cx_next = {1'b0, cx} + WID_BITS'(1);
      cy_next = {1'b0, cy} + (HEIGHT_BITS+1)'(1);
      col_count_in = cx_next[COL_BITS-1:0];
      row_count_in = cy;
      if (cx_next >= width_eff) begin
         col_count_in = '0;
         row_count_in = cy_next[HEIGHT_BITS-1:0];
         if (cy_next >= {1'b0, height_eff}) begin
            row_count_in = '0;
         end
      end
      emit_in = (cx >= COL_BITS'(2)) && ({1'b0, cx} < width_eff) &&
                (cy >= HEIGHT_BITS'(2)) && (cy < height_eff);
      last_in = ({1'b0, cx} == width_eff - WID_BITS'(1)) &&
                (cy == height_eff - HEIGHT_BITS'(1));
      pix_in  = {vec_y, vec_x};
   end

   // same column back to back: the pending write-back is not yet in the ram
   assign s1_fwd_in = s1_valid_ff && (s1_addr_ff == cx);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (in_take) begin
            col_count_ff <= col_count_in;
            row_count_ff <= row_count_in;
         end
         if (move) begin
            s1_valid_ff <= in_take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         s1_emit_ff     <= emit_in;
         s1_last_ff     <= last_in;
         s1_addr_ff     <= cx;
         s1_row_ff      <= cy;
         s1_pix_ff      <= pix_in;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= wr_data;
      end
   end

   assign line_word = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
   assign wr_data   = {line_word[VEC_BITS-1:0], s1_pix_ff};
   assign wr_en     = s1_valid_ff && move;

   gnms_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (in_take),
      .rd_addr (cx),
      .rd_data (rd_data)
   );

   always_comb begin
      col.valid = s1_valid_ff;
      col.emit  = s1_emit_ff;
      col.last  = s1_last_ff;
      col.pos_x = s1_addr_ff - COL_BITS'(1);
      col.pos_y = s1_row_ff - HEIGHT_BITS'(1);
      col.top   = line_word[LINE_BITS-1:VEC_BITS];
      col.mid   = line_word[VEC_BITS-1:0];
      col.pix   = s1_pix_ff;
   end

endmodule

>>> hdl/gnms_window.sv
// squared norms, 3x3 window and the suppression decision
module gnms_window import gnms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       move,
   input  column_type col,
   output result_type res
);

   function automatic logic [COMP_BITS-1:0] abs_comp(input logic [COMP_BITS-1:0] v);
      return v[COMP_BITS-1] ? (~v + COMP_BITS'(1)) : v;
   endfunction

   logic [VEC_BITS-1:0]    col_vec [3];
   logic [COMP_BITS-1:0]   abs_x [3];
   logic [COMP_BITS-1:0]   abs_y [3];
   logic [SQ_BITS-1:0]     sqx_in [3];
   logic [SQ_BITS-1:0]     sqy_in [3];

   logic                   s2_valid_ff, s2_emit_ff, s2_last_ff;
   logic [COL_BITS-1:0]    s2_pos_x_ff;
   logic [HEIGHT_BITS-1:0] s2_pos_y_ff;
   logic [VEC_BITS-1:0]    s2_mid_ff;
   logic [SQ_BITS-1:0]     s2_sqx_ff [3];
   logic [SQ_BITS-1:0]     s2_sqy_ff [3];

   logic [NORM_BITS-1:0]   norm_in [3];
   dir_type                dir_in;

   logic [NORM_BITS-1:0]   norm_ff [3][3];
   logic [VEC_BITS-1:0]    cen_vec_ff, nxt_vec_ff;
   dir_type                cen_dir_ff, nxt_dir_ff;

   logic                   s3_valid_ff, s3_emit_ff, s3_last_ff;
   logic [COL_BITS-1:0]    s3_pos_x_ff;
   logic [HEIGHT_BITS-1:0] s3_pos_y_ff;

   logic [1:0]             fwd_r, fwd_c, bwd_r, bwd_c;
   logic [NORM_BITS-1:0]   self_norm, fwd_norm, bwd_norm;
   logic                   kept;

   always_comb begin
      col_vec[0] = col.top;
      col_vec[1] = col.mid;
      col_vec[2] = col.pix;
      for (int i = 0; i < 3; i++) begin
         abs_x[i]  = abs_comp(col_vec[i][COMP_BITS-1:0]);
         abs_y[i]  = abs_comp(col_vec[i][VEC_BITS-1:COMP_BITS]);
         sqx_in[i] = abs_x[i] * abs_x[i];
         sqy_in[i] = abs_y[i] * abs_y[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (move) begin
         s2_valid_ff <= col.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (move && col.valid) begin
         s2_emit_ff  <= col.emit;
         s2_last_ff  <= col.last;
         s2_pos_x_ff <= col.pos_x;
         s2_pos_y_ff <= col.pos_y;
         s2_mid_ff   <= col.mid;
         for (int i = 0; i < 3; i++) begin
            s2_sqx_ff[i] <= sqx_in[i];
            s2_sqy_ff[i] <= sqy_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         norm_in[i] = {1'b0, s2_sqx_ff[i]} + {1'b0, s2_sqy_ff[i]};
      end
      dir_in.dx = axis_offset(s2_mid_ff[COMP_BITS-1:0] == '0, s2_mid_ff[COMP_BITS-1],
                              s2_sqx_ff[1], s2_sqy_ff[1]);
      dir_in.dy = axis_offset(s2_mid_ff[VEC_BITS-1:COMP_BITS] == '0, s2_mid_ff[VEC_BITS-1],
                              s2_sqy_ff[1], s2_sqx_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         cen_vec_ff  <= '0;
         nxt_vec_ff  <= '0;
         cen_dir_ff  <= '0;
         nxt_dir_ff  <= '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               norm_ff[r][c] <= '0;
            end
         end
      end else if (move) begin
         s3_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            for (int r = 0; r < 3; r++) begin
               norm_ff[r][0] <= norm_ff[r][1];
               norm_ff[r][1] <= norm_ff[r][2];
               norm_ff[r][2] <= norm_in[r];
            end
            cen_vec_ff <= nxt_vec_ff;
            nxt_vec_ff <= s2_mid_ff;
            cen_dir_ff <= nxt_dir_ff;
            nxt_dir_ff <= dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move && s2_valid_ff) begin
         s3_emit_ff  <= s2_emit_ff;
         s3_last_ff  <= s2_last_ff;
         s3_pos_x_ff <= s2_pos_x_ff;
         s3_pos_y_ff <= s2_pos_y_ff;
      end
   end

   always_comb begin
      fwd_r = !cen_dir_ff.dy.nz ? 2'd1 : (cen_dir_ff.dy.neg ? 2'd0 : 2'd2);
      fwd_c = !cen_dir_ff.dx.nz ? 2'd1 : (cen_dir_ff.dx.neg ? 2'd0 : 2'd2);
      bwd_r = 2'd2 - fwd_r;
      bwd_c = 2'd2 - fwd_c;
      self_norm = norm_ff[1][1];
      fwd_norm  = norm_ff[fwd_r][fwd_c];
      bwd_norm  = norm_ff[bwd_r][bwd_c];
      kept = (cen_vec_ff != '0) && (self_norm >= fwd_norm) && (self_norm >= bwd_norm);

      res.valid   = s3_valid_ff && s3_emit_ff;
      res.pos_x   = s3_pos_x_ff;
      res.pos_y   = s3_pos_y_ff;
      res.kept_x  = kept ? cen_vec_ff[COMP_BITS-1:0] : '0;
      res.kept_y  = kept ? cen_vec_ff[VEC_BITS-1:COMP_BITS] : '0;
      res.is_kept = kept;
      res.last    = s3_last_ff;
   end

endmodule

>>> hdl/gradient_non_maximum_suppression.sv
// top level of the gradient non-maximum suppression block
//
//   channel  ports   direction  word
//   req      req_*   in         one pixel vector, raster order
//   rsp      rsp_*   out        one interior pixel result
//   csr      csr_*   in         frame_width (0), frame_height (1)
//
// one word accepted per cycle while req_stall is low; the word that completes a window
// passes the line-store, norm, window and output registers before its result is on rsp
// the line store is one ram, read when a word is taken, written back from the first stage on a move
// reset clears counters and window and loads csr values (640 x 480); the ram is not cleared
// rsp_stall holding a result fills a skid register; req_stall rises the cycle after
module gradient_non_maximum_suppression import gnms_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COMP_BITS-1:0]   req_vec_x,
   input  logic signed [COMP_BITS-1:0]   req_vec_y,
   input  logic                          req_frame_start,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [COL_BITS-1:0]           rsp_pos_x,
   output logic [HEIGHT_BITS-1:0]        rsp_pos_y,
   output logic signed [COMP_BITS-1:0]   rsp_kept_x,
   output logic signed [COMP_BITS-1:0]   rsp_kept_y,
   output logic                          rsp_is_kept,
   output logic                          rsp_frame_last,

   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   logic [CSR_WIDTH_BITS-1:0]  frame_width_ff;
   logic [CSR_HEIGHT_BITS-1:0] frame_height_ff;
   logic [WID_BITS-1:0]        width_eff;
   logic [HEIGHT_BITS-1:0]     height_eff;

   logic       move, in_take, out_take;
   column_type col;
   result_type res;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[CSR_WIDTH_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[CSR_HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff < CSR_WIDTH_BITS'(3)) begin
         width_eff = WID_BITS'(3);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         width_eff = WID_BITS'(MAX_WIDTH);
      end else begin
         width_eff = WID_BITS'(frame_width_ff);
      end
      height_eff = (frame_height_ff < CSR_HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : frame_height_ff;
   end

   assign move      = !skid_ff.valid;
   assign in_take   = req_valid && move;
   assign req_stall = skid_ff.valid;
   assign out_take  = out_ff.valid && !rsp_stall;

   gnms_line_store u_line_store (
      .clock       (clock),
      .reset       (reset),
      .move        (move),
      .in_take     (in_take),
      .frame_start (req_frame_start),
      .vec_x       (req_vec_x),
      .vec_y       (req_vec_y),
      .width_eff   (width_eff),
      .height_eff  (height_eff),
      .col         (col)
   );

   gnms_window u_window (
      .clock (clock),
      .reset (reset),
      .move  (move),
      .col   (col),
      .res   (res)
   );

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (skid_ff.valid) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_in.valid = 1'b0;
         end
      end else if (res.valid) begin
         if (!out_ff.valid || out_take) begin
            out_in = res;
         end else begin
            skid_in = res;
         end
      end else if (out_take) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff  <= '0;
         skid_ff <= '0;
      end else begin
         out_ff  <= out_in;
         skid_ff <= skid_in;
      end
   end

   assign rsp_valid      = out_ff.valid;
   assign rsp_pos_x      = out_ff.pos_x;
   assign rsp_pos_y      = out_ff.pos_y;
   assign rsp_kept_x     = out_ff.kept_x;
   assign rsp_kept_y     = out_ff.kept_y;
   assign rsp_is_kept    = out_ff.is_kept;
   assign rsp_frame_last = out_ff.last;

endmodule

>>> hdl/gnms_checker.sv
// port-level checks for the gradient non-maximum suppression block
module gnms_checker import gnms_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [COL_BITS-1:0]         rsp_pos_x,
   input logic [HEIGHT_BITS-1:0]      rsp_pos_y,
   input logic signed [COMP_BITS-1:0] rsp_kept_x,
   input logic signed [COMP_BITS-1:0] rsp_kept_y,
   input logic                        rsp_is_kept
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) &&
                                 $stable(rsp_kept_x) && $stable(rsp_kept_y))
      else $error("stalled rsp word changed");

   // suppressed pixels carry a zero vector
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_kept |-> rsp_kept_x == '0 && rsp_kept_y == '0)
      else $error("suppressed pixel has nonzero vector");

   // no pixel of the top row or left column is reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pos_x != '0 && rsp_pos_y != '0)
      else $error("border pixel reported");

   // input back-pressure only follows a held result
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall rose without a stalled result");

endmodule

bind gradient_non_maximum_suppression gnms_checker u_gnms_checker (.*);
